// ===== src/izh_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Izhikevich neuron step block.
// Used by the front end, the update engine and the top level.
// Depends on nothing else.
package izh_pkg;

    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes, in register-file order.
    typedef enum logic [2:0] {
        REG_GAIN_V  = 3'd0,
        REG_STEP_V  = 3'd1,
        REG_RATE_U  = 3'd2,
        REG_SENS_B  = 3'd3,
        REG_JUMP_D  = 3'd4,
        REG_THR_VT  = 3'd5,
        REG_REST_VR = 3'd6,
        REG_PEAK_V  = 3'd7
    } cfg_reg_t;

    localparam logic signed [31:0] GAIN_V_RST  = 32'sd107374;
    localparam logic signed [31:0] STEP_V_RST  = 32'sd42950;
    localparam logic signed [31:0] RATE_U_RST  = 32'sd107374;
    localparam logic signed [31:0] SENS_B_RST  = -32'sd536870912;
    localparam logic signed [31:0] JUMP_D_RST  = 32'sd13107200;
    localparam logic signed [31:0] THR_VT_RST  = -32'sd2621440;
    localparam logic signed [31:0] REST_VR_RST = -32'sd3932160;
    localparam logic signed [31:0] PEAK_V_RST  = 32'sd1966080;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] weight_or_voltage;
        logic signed [31:0] presyn_value;
        logic               last_synapse;
        logic signed [31:0] bias_current;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] voltage;
        logic signed [31:0] recovery;
        logic               spiked;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] gain_v;
        logic signed [31:0] step_v;
        logic signed [31:0] rate_u;
        logic signed [31:0] sens_b;
        logic signed [31:0] jump_d;
        logic signed [31:0] thr_vt;
        logic signed [31:0] rest_vr;
        logic signed [31:0] peak_v;
    } cfg_t;

    // Command kinds handed from the front end to the update engine.
    typedef enum logic [1:0] {
        CMD_ACC  = 2'd0,
        CMD_LAST = 2'd1,
        CMD_INIT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [63:0] product;
        logic signed [31:0] bias;
        logic signed [31:0] voltage;
    } cmd_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sh0_7FFF_FFFF;
        lo = -66'sh0_8000_0000;
        if (x > hi)
            return 32'sh7FFF_FFFF;
        else if (x < lo)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

    // Signed 64-bit add that saturates instead of wrapping.
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63])
            return sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            return sum[63:0];
    endfunction

endpackage

// ===== src/izhikevich_neuron_step.sv =====
// Top level of the Izhikevich neuron step block: configuration registers, front end,
// command queue and update engine. Depends on izh_pkg, izh_front, izh_queue, izh_back.
//
// One neuron, advanced one forward-Euler step per batch of synapse items. A synapse
// item transfers a Q16.16 weight and presynaptic value; their full 64-bit product is
// added to a saturating Q32.32 accumulator. Synapse items are taken one per clock
// cycle while the queue has room: the front end multiplies, a QUEUE_DEPTH-entry
// queue holds the commands, and the update engine adds one product per cycle while
// no update is in progress. An item marked last_synapse adds its product and then the
// bias current, and starts the neuron update on one shared 32x32 multiplier (bias add,
// differences, five multiplies with their scaling steps, and the final spike test).
// While that update runs, the queue keeps taking input until it is full. The result
// (voltage, recovery, spiked) sits in an output register, so the engine continues with
// the next batch while a result waits to be taken; a second last item waits only if
// the previous result has not yet been transferred. An item with req_type set loads the
// voltage, clears recovery and the accumulator, and produces no result.
// Configuration registers are written through the cfg port, which is always ready;
// write them only while the block is idle.
module izhikevich_neuron_step
    import izh_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t             cfg_reg;
    logic             push_valid;
    logic             push_ready;
    cmd_t             push_cmd;
    logic             pop_valid;
    logic             pop_ready;
    logic [$bits(cmd_t)-1:0] pop_bits;
    cmd_t             pop_cmd;

    // Every register write is accepted as it comes, so the port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_v  <= GAIN_V_RST;
            cfg_reg.step_v  <= STEP_V_RST;
            cfg_reg.rate_u  <= RATE_U_RST;
            cfg_reg.sens_b  <= SENS_B_RST;
            cfg_reg.jump_d  <= JUMP_D_RST;
            cfg_reg.thr_vt  <= THR_VT_RST;
            cfg_reg.rest_vr <= REST_VR_RST;
            cfg_reg.peak_v  <= PEAK_V_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_V:  cfg_reg.gain_v  <= cfg_data;
                REG_STEP_V:  cfg_reg.step_v  <= cfg_data;
                REG_RATE_U:  cfg_reg.rate_u  <= cfg_data;
                REG_SENS_B:  cfg_reg.sens_b  <= cfg_data;
                REG_JUMP_D:  cfg_reg.jump_d  <= cfg_data;
                REG_THR_VT:  cfg_reg.thr_vt  <= cfg_data;
                REG_REST_VR: cfg_reg.rest_vr <= cfg_data;
                REG_PEAK_V:  cfg_reg.peak_v  <= cfg_data;
            endcase
        end
    end

    // The front end classifies each transfer and forms the synapse product.
    izh_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd)
    );

    // The queue lets the front end keep taking items during a neuron update.
    izh_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_bits)
    );

    assign pop_cmd = cmd_t'(pop_bits);

    // The engine accumulates, runs the Euler step and owns the output register.
    izh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== src/izh_front.sv =====
// Front end of the neuron step block: classifies each input item and forms the
// full-precision synapse product. Depends on izh_pkg.
module izh_front
    import izh_pkg::*;
(
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     push_valid,
    input  logic     push_ready,
    output cmd_t     push_data
);

    logic signed [63:0] product;

    // The product is registered in the queue entry before it is accumulated.
    assign product = in_data.weight_or_voltage * in_data.presyn_value;

    always_comb
    begin
        push_data.product = product;
        push_data.bias    = in_data.bias_current;
        push_data.voltage = in_data.weight_or_voltage;
        if (in_data.req_type)
            push_data.kind = CMD_INIT;
        else if (in_data.last_synapse)
            push_data.kind = CMD_LAST;
        else
            push_data.kind = CMD_ACC;
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

// ===== src/izh_queue.sv =====
// Small register-based FIFO that decouples the front end from the update engine.
// Generic width and depth; depends on no package.
module izh_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop_fire)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push_fire && !pop_fire)
                count_reg <= count_reg + 1'b1;
            else if (pop_fire && !push_fire)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire && !pop_fire |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a lone push");

endmodule

// ===== src/izh_back.sv =====
// Update engine: accumulates synapse products and runs the Euler step of v and u
// on a shared multiplier, then holds the result in an output register. Depends on izh_pkg.
module izh_back
    import izh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  cmd_t      pop_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    typedef enum logic [3:0] {
        S_ACC, S_BIAS, S_DIFF, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_DONE
    } state_t;

    state_t             state_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] bias_reg;
    logic signed [31:0] cur_reg;
    logic signed [31:0] dr_reg;
    logic signed [31:0] dt_reg;
    logic signed [31:0] ci_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] w_reg;
    logic signed [39:0] vsum_reg;
    logic signed [63:0] prod_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic               mul_en;
    logic signed [39:0] prod_q28;
    logic signed [63:0] bias_q32;
    logic signed [32:0] diff_r;
    logic signed [32:0] diff_t;
    logic signed [32:0] diff_i;
    logic signed [39:0] w_wide;
    logic signed [31:0] vn;
    logic signed [31:0] un0;
    logic signed [31:0] un;
    logic               spike;
    logic               done_fire;

    assign pop_ready = (state_reg == S_ACC);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Floor of the product over 2^28 always fits in 36 bits.
    assign prod_q28 = 40'(prod_reg >>> 28);
    assign bias_q32 = {{16{bias_reg[31]}}, bias_reg, 16'd0};
    assign diff_r   = 33'(v_reg) - 33'(cfg.rest_vr);
    assign diff_t   = 33'(v_reg) - 33'(cfg.thr_vt);
    assign diff_i   = 33'(cur_reg) - 33'(u_reg);
    assign w_wide   = prod_q28 - 40'(u_reg);

    assign vn    = sat32(66'(vsum_reg));
    assign un0   = sat32(66'(40'(u_reg) + prod_q28));
    assign spike = (vn >= cfg.peak_v);
    assign un    = spike ? sat32(66'(33'(un0) + 33'(cfg.jump_d))) : un0;

    assign done_fire = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a  = dr_reg;
        mul_b  = dt_reg;
        mul_en = 1'b1;
        unique case (state_reg)
            S_M1:
            begin
                mul_a = dr_reg;
                mul_b = dt_reg;
            end
            S_M2:
            begin
                mul_a = cfg.step_v;
                mul_b = ci_reg;
            end
            S_M3:
            begin
                mul_a = cfg.gain_v;
                mul_b = q_reg;
            end
            S_M4:
            begin
                mul_a = cfg.sens_b;
                mul_b = dr_reg;
            end
            S_M6:
            begin
                mul_a = cfg.rate_u;
                mul_b = w_reg;
            end
            S_ACC, S_BIAS, S_DIFF, S_M5, S_DONE:
                mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            acc_reg       <= '0;
            v_reg         <= '0;
            u_reg         <= '0;
            bias_reg      <= '0;
            cur_reg       <= '0;
            dr_reg        <= '0;
            dt_reg        <= '0;
            ci_reg        <= '0;
            q_reg         <= '0;
            w_reg         <= '0;
            vsum_reg      <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (mul_en)
                prod_reg <= mul_a * mul_b;

            if (done_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_ACC:
                begin
                    if (pop_valid)
                    begin
                        unique case (pop_data.kind)
                            CMD_INIT:
                            begin
                                v_reg   <= pop_data.voltage;
                                u_reg   <= '0;
                                acc_reg <= '0;
                            end
                            CMD_LAST:
                            begin
                                acc_reg   <= sat_add64(acc_reg, pop_data.product);
                                bias_reg  <= pop_data.bias;
                                state_reg <= S_BIAS;
                            end
                            CMD_ACC:
                                acc_reg <= sat_add64(acc_reg, pop_data.product);
                            default:
                                acc_reg <= acc_reg;
                        endcase
                    end
                end
                S_BIAS:
                begin
                    acc_reg   <= sat_add64(acc_reg, bias_q32);
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    cur_reg   <= sat32(66'(acc_reg >>> 16));
                    acc_reg   <= '0;
                    dr_reg    <= sat32(66'(diff_r));
                    dt_reg    <= sat32(66'(diff_t));
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    ci_reg    <= sat32(66'(diff_i));
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    q_reg     <= sat32(66'(prod_reg >>> 16));
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    vsum_reg  <= 40'(v_reg) + prod_q28;
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    vsum_reg  <= vsum_reg + prod_q28;
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    w_reg     <= sat32(66'(w_wide));
                    state_reg <= S_M6;
                end
                S_M6:
                    state_reg <= S_DONE;
                S_DONE:
                begin
                    if (done_fire)
                    begin
                        v_reg                 <= spike ? cfg.peak_v : vn;
                        u_reg                 <= un;
                        out_data_reg.voltage  <= spike ? cfg.peak_v : vn;
                        out_data_reg.recovery <= un;
                        out_data_reg.spiked   <= spike;
                        state_reg             <= S_ACC;
                    end
                end
            endcase
        end
    end

    a_spike_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.spiked |-> out_data_reg.voltage == cfg.peak_v)
        else $error("spike reported without clamping voltage to the peak");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIFF |=> acc_reg == '0)
        else $error("accumulator not cleared after the current was taken");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && !out_valid_reg |=> out_valid_reg && state_reg == S_ACC)
        else $error("finished step did not reach a free output register");

endmodule
